@@ src/bsad_pkg.sv @@
package bsad_pkg;

	localparam int DATA_W = 16;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} bsad_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
		logic                     overflow;
	} bsad_out_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT_DN,
		OP_SHIFT_UP
	} cell_op_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t                 op;
		logic signed [DATA_W-1:0] x;
	} cell_ctl_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
		logic                     ins;
	} cell_link_t;

endpackage

@@ src/batch_sorter_asc_desc_top.sv @@
// Batch sorter, ascending or descending.
// Requests: an element is taken at a rising edge with start high and busy low.
// Elements stream in one per cycle while loading; each one is placed in
// order in a chain of cells that keeps the batch sorted smallest first.
// Elements beyond MAX_ENTRIES are dropped and flag overflow on every
// result of that batch.
// The element with req.last ends the batch. From the next cycle busy is high
// and the batch leaves on res, one result per cycle once the first is out,
// each shown for one cycle with strobe high; res.final_res marks the last.
// Ascending order pops the bottom cell, which holds the smallest element.
// Descending order shifts the chain upward and pops the top cell; the first
// result waits until the largest element has shifted up into the top cell.
// busy drops with the final result, and the next request may follow in
// that same cycle.
// The receiver cannot stall, so results are never held back.
// Configuration: cfg_ready is always high; cfg_data selects descending (1)
// or ascending (0). The value in force when the last request is taken
// applies to the batch.
// Reset: chain empty, count and overflow cleared, descending order selected.
module batch_sorter_asc_desc_top #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bsad_pkg::bsad_in_t  req,
	output logic                strobe,
	output bsad_pkg::bsad_out_t res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	import bsad_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] remain_q;
	logic       drop_q;
	logic       desc_q;
	logic       desc_lat_q;
	logic       ovf_lat_q;
	logic       strobe_q;
	bsad_out_t  res_q;

	cell_ctl_t  ctl;
	cell_link_t bottom;
	cell_link_t top;
	logic       full;
	logic       take;
	logic       emit_fire;

	assign full      = (cnt_q == CW'(MAX_ENTRIES));
	assign take      = (state_q == ST_LOAD) && start;
	// ascending: bottom cell always holds a pending element while emitting
	assign emit_fire = (state_q == ST_EMIT) && (desc_lat_q ? top.valid : 1'b1);

	// drive the chain: insert while loading (unless full), shift toward the output end
	always_comb begin
		ctl.x  = req.value;
		ctl.op = OP_HOLD;
		if (take && !full) begin
			ctl.op = OP_INSERT;
		end else if (state_q == ST_EMIT) begin
			ctl.op = desc_lat_q ? OP_SHIFT_UP : OP_SHIFT_DN;
		end
	end

	bsad_chain #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.bottom (bottom),
		.top    (top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			remain_q   <= '0;
			drop_q     <= 1'b0;
			desc_q     <= 1'b1;
			desc_lat_q <= 1'b1;
			ovf_lat_q  <= 1'b0;
			strobe_q   <= 1'b0;
			res_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid) begin
				desc_q <= cfg_data;
			end
			case (state_q)
				ST_LOAD: begin
					if (start) begin
						if (!full) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (req.last) begin
							// close the batch: latch its count, flag and order
							remain_q   <= full ? cnt_q : cnt_q + CW'(1);
							ovf_lat_q  <= drop_q | full;
							desc_lat_q <= desc_q;
							cnt_q      <= '0;
							drop_q     <= 1'b0;
							state_q    <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						res_q.sorted_value <= desc_lat_q ? top.value : bottom.value;
						res_q.final_res    <= (remain_q == CW'(1));
						res_q.overflow     <= ovf_lat_q;
						strobe_q           <= 1'b1;
						remain_q           <= remain_q - CW'(1);
						if (remain_q == CW'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign busy      = (state_q == ST_EMIT);
	assign strobe    = strobe_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

endmodule

@@ src/bsad_cell.sv @@
module bsad_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bsad_pkg::cell_ctl_t ctl,
	input  bsad_pkg::cell_link_t lo,
	input  bsad_pkg::cell_link_t hi,
	output bsad_pkg::cell_link_t link
);
	import bsad_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     ins;

	// new value belongs at or below this cell
	assign ins = !valid_q || ($signed(ctl.x) < $signed(value_q));

	assign link.valid = valid_q;
	assign link.value = value_q;
	assign link.ins   = ins;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_INSERT: begin
					if (ins) begin
						valid_q <= lo.ins ? lo.valid : 1'b1;
					end
				end
				OP_SHIFT_DN: valid_q <= hi.valid;
				OP_SHIFT_UP: valid_q <= lo.valid;
				default:     valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (ins) begin
					value_q <= lo.ins ? lo.value : ctl.x;
				end
			end
			OP_SHIFT_DN: value_q <= hi.value;
			OP_SHIFT_UP: value_q <= lo.value;
			default:     value_q <= value_q;
		endcase
	end

endmodule

@@ src/bsad_chain.sv @@
module bsad_chain #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bsad_pkg::cell_ctl_t  ctl,
	output bsad_pkg::cell_link_t bottom,
	output bsad_pkg::cell_link_t top
);
	import bsad_pkg::*;

	cell_link_t links [MAX_ENTRIES];
	cell_link_t edge_lnk;

	// beyond either end: an empty cell that never claims an insert
	assign edge_lnk = '{valid: 1'b0, value: '0, ins: 1'b0};

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cell_link_t lo_l, hi_l;
		if (i == 0) begin : g_lo_edge
			assign lo_l = edge_lnk;
		end else begin : g_lo
			assign lo_l = links[i-1];
		end
		if (i == MAX_ENTRIES - 1) begin : g_hi_edge
			assign hi_l = edge_lnk;
		end else begin : g_hi
			assign hi_l = links[i+1];
		end
		bsad_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.lo     (lo_l),
			.hi     (hi_l),
			.link   (links[i])
		);
	end

	assign bottom = links[0];
	assign top    = links[MAX_ENTRIES-1];

endmodule
